@@ sv/utt_pkg.sv @@
`default_nettype none

package utt_pkg;

   // Counter width default and fixed result field widths
   localparam int COUNT_BITS_DEFAULT = 24;
   localparam int FIELD_CNT_W        = 24;
   localparam int MAX_RESULTS        = 3;
   localparam int ACC_W              = 21;

   // Lead byte bounds
   localparam logic [7:0] LEAD_MIN  = 8'hC2;
   localparam logic [7:0] LEAD_MAX  = 8'hF4;
   localparam logic [7:0] LEAD3_MIN = 8'hE0;
   localparam logic [7:0] LEAD4_MIN = 8'hF0;

   // Leads whose second byte has a narrowed range
   localparam logic [7:0] LEAD_E0 = 8'hE0;
   localparam logic [7:0] LEAD_ED = 8'hED;
   localparam logic [7:0] LEAD_F0 = 8'hF0;
   localparam logic [7:0] LEAD_F4 = 8'hF4;

   // Continuation bounds
   localparam logic [7:0] CONT_MIN     = 8'h80;
   localparam logic [7:0] CONT_MAX     = 8'hBF;
   localparam logic [7:0] AFTER_E0_MIN = 8'hA0;
   localparam logic [7:0] AFTER_ED_MAX = 8'h9F;
   localparam logic [7:0] AFTER_F0_MIN = 8'h90;
   localparam logic [7:0] AFTER_F4_MAX = 8'h8F;

   // Surrogate construction
   localparam logic [ACC_W-1:0] SUPP_BASE = 21'h010000;
   localparam logic [15:0]      HI_SURR   = 16'hD800;
   localparam logic [15:0]      LO_SURR   = 16'hDC00;

   typedef enum logic [1:0] {
      KIND_UNIT      = 2'd0,
      KIND_DONE      = 2'd1,
      KIND_ILLEGAL   = 2'd2,
      KIND_EXHAUSTED = 2'd3
   } kind_type;

   // All results caused by one source byte
   typedef struct packed {
      logic [1:0]                   count;
      logic [MAX_RESULTS-1:0][15:0] unit;
      kind_type [MAX_RESULTS-1:0]   kind;
      logic [FIELD_CNT_W-1:0]       chars;
      logic [FIELD_CNT_W-1:0]       bytes;
      logic [FIELD_CNT_W-1:0]       units;
   } result_group_type;

endpackage

`default_nettype wire

@@ sv/utf8_to_utf16_transcoder.sv @@
`default_nettype none

// Channel   Direction  Handshake               Payload
// req_      in         req_valid / req_ready   data_byte[7:0], end_of_source
// rsp_      out        rsp_valid / rsp_ready   code_unit[15:0], result_kind[1:0],
//                                              run_last, chars/bytes/units_done[23:0]
//
// One source byte is accepted per cycle unless results are still waiting. A byte
// yields zero to three result beats, sent one per cycle while rsp_ready is high.
// A byte passes the input register and the result group register before its
// first result is offered. The input register takes one more byte while
// results wait. Reset is synchronous and clears all stream state.

module utf8_to_utf16_transcoder #(
   parameter int COUNT_BITS = utt_pkg::COUNT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_source,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_code_unit,
   output logic [1:0]  rsp_result_kind,
   output logic        rsp_run_last,
   output logic [23:0] rsp_chars_done,
   output logic [23:0] rsp_bytes_done,
   output logic [23:0] rsp_units_done
);
   import utt_pkg::*;

   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic             in_eos_ff;
   logic             q_free;
   logic             step_fire;
   logic             grp_load;
   result_group_type group;

   assign step_fire = in_valid_ff && q_free;
   assign grp_load  = step_fire && (group.count != 2'd0);
   assign req_ready = !in_valid_ff || step_fire;

   // Hold one input beat ahead of the decoder
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_eos_ff  <= req_end_of_source;
      end
   end

   utt_step #(
      .COUNT_BITS(COUNT_BITS)
   ) u_step (
      .clock         (clock),
      .reset         (reset),
      .fire          (step_fire),
      .data_byte     (in_byte_ff),
      .end_of_source (in_eos_ff),
      .group         (group)
   );

   utt_rsp_queue u_queue (
      .clock           (clock),
      .reset           (reset),
      .load            (grp_load),
      .group           (group),
      .free            (q_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_unit   (rsp_code_unit),
      .rsp_result_kind (rsp_result_kind),
      .rsp_run_last    (rsp_run_last),
      .rsp_chars_done  (rsp_chars_done),
      .rsp_bytes_done  (rsp_bytes_done),
      .rsp_units_done  (rsp_units_done)
   );

   // A status beat always closes its byte's results
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != KIND_UNIT |-> rsp_run_last)
      else $error("status beat not marked last");

   // A status beat carries no code unit
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != KIND_UNIT |-> rsp_code_unit == 16'd0)
      else $error("status beat with nonzero code unit");

   // More results of the same byte follow at once
   a_group_cont: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_run_last |=> rsp_valid)
      else $error("result group broken off");

   // Decoder only advances while the input register holds a beat
   a_fire_src: assert property (@(posedge clock) disable iff (reset)
      step_fire |-> in_valid_ff && req_ready)
      else $error("decode without input beat");

endmodule

`default_nettype wire

@@ sv/utt_step.sv @@
`default_nettype none

module utt_step #(
   parameter int COUNT_BITS = utt_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  logic [7:0]                data_byte,
   input  logic                      end_of_source,
   output utt_pkg::result_group_type group
);
   import utt_pkg::*;

   logic [ACC_W-1:0]      acc_ff, acc_in;
   logic [1:0]            rem_ff, rem_in;
   logic [2:0]            len_ff, len_in;
   logic [7:0]            lead_ff, lead_in;
   logic                  halted_ff, halted_in;
   logic [COUNT_BITS-1:0] chr_ff, chr_in;
   logic [COUNT_BITS-1:0] byt_ff, byt_in;
   logic [COUNT_BITS-1:0] unt_ff, unt_in;

   function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
                                                     input logic [2:0] b);
      logic [COUNT_BITS:0] s;
      s = {1'b0, a} + (COUNT_BITS+1)'(b);
      return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
   endfunction

   // Decode one byte against the held sequence state
   always_comb begin
      logic             finish;
      logic             illegal;
      logic             ok;
      logic [ACC_W-1:0] cp;
      logic [ACC_W-1:0] acc_shift;
      logic [ACC_W-1:0] v;
      logic [2:0]       flen;
      logic             pair;
      logic [1:0]       n;

      acc_in    = acc_ff;
      rem_in    = rem_ff;
      len_in    = len_ff;
      lead_in   = lead_ff;
      halted_in = halted_ff;
      chr_in    = chr_ff;
      byt_in    = byt_ff;
      unt_in    = unt_ff;
      finish    = 1'b0;
      illegal   = 1'b0;
      ok        = 1'b1;
      cp        = '0;
      acc_shift = '0;
      v         = '0;
      flen      = 3'd0;
      pair      = 1'b0;
      n         = 2'd0;
      group     = '0;

      if (!halted_ff) begin
         if (rem_ff == 2'd0) begin
            if (!data_byte[7]) begin
               finish = 1'b1;
               cp     = {13'd0, data_byte};
               flen   = 3'd1;
            end else if (data_byte < LEAD_MIN || data_byte > LEAD_MAX) begin
               illegal = 1'b1;
            end else begin
               // Start a multi-byte sequence
               if (data_byte < LEAD3_MIN) begin
                  len_in = 3'd2;
                  rem_in = 2'd1;
                  acc_in = {16'd0, data_byte[4:0]};
               end else if (data_byte < LEAD4_MIN) begin
                  len_in = 3'd3;
                  rem_in = 2'd2;
                  acc_in = {17'd0, data_byte[3:0]};
               end else begin
                  len_in = 3'd4;
                  rem_in = 2'd3;
                  acc_in = {18'd0, data_byte[2:0]};
               end
               lead_in = data_byte;
            end
         end else begin
            ok = (data_byte >= CONT_MIN) && (data_byte <= CONT_MAX);
            // Narrow the second byte after the special leads
            if (len_ff - {1'b0, rem_ff} == 3'd1) begin
               if (lead_ff == LEAD_E0 && data_byte < AFTER_E0_MIN) ok = 1'b0;
               if (lead_ff == LEAD_ED && data_byte > AFTER_ED_MAX) ok = 1'b0;
               if (lead_ff == LEAD_F0 && data_byte < AFTER_F0_MIN) ok = 1'b0;
               if (lead_ff == LEAD_F4 && data_byte > AFTER_F4_MAX) ok = 1'b0;
            end
            if (!ok) begin
               illegal = 1'b1;
            end else begin
               acc_shift = {acc_ff[ACC_W-7:0], data_byte[5:0]};
               acc_in    = acc_shift;
               rem_in    = rem_ff - 2'd1;
               if (rem_ff == 2'd1) begin
                  finish = 1'b1;
                  cp     = acc_shift;
                  flen   = len_ff;
               end
            end
         end
      end

      // Complete a character: count it and emit one unit or a pair
      if (finish) begin
         pair   = |cp[ACC_W-1:16];
         v      = cp - SUPP_BASE;
         chr_in = sat_add(chr_ff, 3'd1);
         byt_in = sat_add(byt_ff, flen);
         unt_in = sat_add(unt_ff, pair ? 3'd2 : 3'd1);
         if (pair) begin
            group.unit[0] = HI_SURR + {6'd0, v[19:10]};
            group.unit[1] = LO_SURR + {6'd0, v[9:0]};
            group.kind[0] = KIND_UNIT;
            group.kind[1] = KIND_UNIT;
            n = 2'd2;
         end else begin
            group.unit[0] = cp[15:0];
            group.kind[0] = KIND_UNIT;
            n = 2'd1;
         end
         acc_in  = '0;
         rem_in  = 2'd0;
         len_in  = 3'd0;
         lead_in = 8'd0;
      end

      // Report a bad byte and halt
      if (illegal) begin
         group.unit[0] = 16'd0;
         group.kind[0] = KIND_ILLEGAL;
         n         = 2'd1;
         acc_in    = '0;
         rem_in    = 2'd0;
         len_in    = 3'd0;
         lead_in   = 8'd0;
         halted_in = 1'b1;
      end

      group.chars = FIELD_CNT_W'(chr_in);
      group.bytes = FIELD_CNT_W'(byt_in);
      group.units = FIELD_CNT_W'(unt_in);

      // Close the stream: append status unless halted, then drop all stream state
      if (end_of_source) begin
         if (!halted_in) begin
            group.unit[n] = 16'd0;
            group.kind[n] = (rem_in != 2'd0) ? KIND_EXHAUSTED : KIND_DONE;
            n = n + 2'd1;
         end
         acc_in    = '0;
         rem_in    = 2'd0;
         len_in    = 3'd0;
         lead_in   = 8'd0;
         halted_in = 1'b0;
         chr_in    = '0;
         byt_in    = '0;
         unt_in    = '0;
      end

      group.count = n;
   end

   // Hold stream state, advance on each decoded byte
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         rem_ff    <= 2'd0;
         len_ff    <= 3'd0;
         lead_ff   <= 8'd0;
         halted_ff <= 1'b0;
         chr_ff    <= '0;
         byt_ff    <= '0;
         unt_ff    <= '0;
      end else if (fire) begin
         acc_ff    <= acc_in;
         rem_ff    <= rem_in;
         len_ff    <= len_in;
         lead_ff   <= lead_in;
         halted_ff <= halted_in;
         chr_ff    <= chr_in;
         byt_ff    <= byt_in;
         unt_ff    <= unt_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/utt_rsp_queue.sv @@
`default_nettype none

module utt_rsp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  utt_pkg::result_group_type group,
   output logic                      free,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [15:0]               rsp_code_unit,
   output logic [1:0]                rsp_result_kind,
   output logic                      rsp_run_last,
   output logic [23:0]               rsp_chars_done,
   output logic [23:0]               rsp_bytes_done,
   output logic [23:0]               rsp_units_done
);
   import utt_pkg::*;

   logic             busy_ff;
   logic [1:0]       idx_ff;
   result_group_type grp_ff;
   logic             last;
   logic             take;

   assign last = (idx_ff == grp_ff.count - 2'd1);
   assign take = busy_ff && rsp_ready;
   assign free = !busy_ff || (take && last);

   // Step through the held group, one beat per result
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else if (load) begin
         busy_ff <= 1'b1;
         idx_ff  <= 2'd0;
      end else if (take) begin
         if (last) begin
            busy_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + 2'd1;
         end
      end
   end

   // Capture a new group
   always_ff @(posedge clock) begin
      if (load) begin
         grp_ff <= group;
      end
   end

   assign rsp_valid       = busy_ff;
   assign rsp_code_unit   = grp_ff.unit[idx_ff];
   assign rsp_result_kind = grp_ff.kind[idx_ff];
   assign rsp_run_last    = last;
   assign rsp_chars_done  = grp_ff.chars;
   assign rsp_bytes_done  = grp_ff.bytes;
   assign rsp_units_done  = grp_ff.units;

endmodule

`default_nettype wire
